/* design/assert_macros.svh */
// assertion macros shared by the window median design
// no dependencies; expects aclk and aresetn in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property checked at every edge outside reset
`define FWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// condition in one cycle implies an expectation in the next
`define FWM_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (nxt)) \
        else $error(msg);

`else

`define FWM_ASSERT(lbl, prop, msg)

`define FWM_ASSERT_NEXT(lbl, cond, nxt, msg)

`endif

`endif

/* design/fwm_pkg.sv */
// shared types, codes and helpers of the window median block
// no dependencies
package fwm_pkg;

    localparam int VALUE_W     = 32;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 9;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 48;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_NOP    = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_REMOVE_EMPTY = 2'd2,
        ST_QUERY_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    typedef enum logic {
        CHAIN_INSERT,
        CHAIN_REMOVE
    } chain_op_t;

    typedef struct packed {
        logic      en;
        chain_op_t op;
    } chain_ctrl_t;

    function automatic logic signed_less(input logic signed [VALUE_W-1:0] a,
                                         input logic signed [VALUE_W-1:0] b);
        return a < b;
    endfunction

endpackage

/* design/fwm_cell.sv */
// one cell of the sorted row: holds a value, shifts to or from a neighbour
// depends on fwm_pkg
module fwm_cell (
    input  logic                                  aclk,
    input  fwm_pkg::chain_ctrl_t                  ctrl,
    input  logic signed [fwm_pkg::VALUE_W-1:0]    key,
    input  logic                                  occ,
    input  logic signed [fwm_pkg::VALUE_W-1:0]    left_val,
    input  logic                                  left_flag,
    input  logic signed [fwm_pkg::VALUE_W-1:0]    right_val,
    input  logic                                  right_flag,
    output logic signed [fwm_pkg::VALUE_W-1:0]    val,
    output logic                                  flag
);
    import fwm_pkg::*;

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;

    // set when the key belongs at or before this cell
    assign flag = !occ || signed_less(key, val_reg);
    assign val  = val_reg;

    always_comb begin
        val_next = val_reg;
        if (ctrl.en) begin
            case (ctrl.op)
                CHAIN_INSERT: begin
                    if (left_flag) begin
                        val_next = left_val;
                    end else if (flag) begin
                        val_next = key;
                    end
                end
                CHAIN_REMOVE: begin
                    if (occ && right_flag) begin
                        val_next = right_val;
                    end
                end
                default: val_next = val_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule

/* design/fwm_sort_chain.sv */
// row of sorted cells with the upper median select
// depends on fwm_pkg and fwm_cell
module fwm_sort_chain #(
    parameter int DEPTH = 256
) (
    input  logic                                  aclk,
    input  fwm_pkg::chain_ctrl_t                  ctrl,
    input  logic signed [fwm_pkg::VALUE_W-1:0]    key,
    input  logic [$clog2(DEPTH+1)-1:0]            count,
    output logic signed [fwm_pkg::VALUE_W-1:0]    median
);
    import fwm_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);

    logic signed [VALUE_W-1:0] vals [DEPTH];
    logic                      flags [DEPTH];
    logic                      occ [DEPTH];
    logic signed [VALUE_W-1:0] lv [DEPTH];
    logic signed [VALUE_W-1:0] rv [DEPTH];
    logic                      lf [DEPTH];
    logic                      rf [DEPTH];
    logic [AW-1:0]             med_idx;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign occ[g] = (count > CW'(g));

        if (g == 0) begin : g_first
            assign lv[g] = key;
            assign lf[g] = 1'b0;
        end else begin : g_mid_l
            assign lv[g] = vals[g-1];
            assign lf[g] = flags[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign rv[g] = key;
            assign rf[g] = 1'b1;
        end else begin : g_mid_r
            assign rv[g] = vals[g+1];
            assign rf[g] = flags[g+1];
        end

        fwm_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .key        (key),
            .occ        (occ[g]),
            .left_val   (lv[g]),
            .left_flag  (lf[g]),
            .right_val  (rv[g]),
            .right_flag (rf[g]),
            .val        (vals[g]),
            .flag       (flags[g])
        );
    end

    // upper median sits at sorted index count/2
    assign med_idx = AW'(count >> 1);
    assign median  = (count == '0) ? '0 : vals[med_idx];

endmodule

/* design/fifo_window_median.sv */
// window median: one item at a time, through accept, the cell row update and the result
// register; no input is taken until that register is loaded, which waits while an older
// result is untaken; the next input is taken while a result still waits
// reset: synchronous active-low aresetn clears count, ring pointers and state, no input
// taken in reset; the sorted cells and the arrival memory keep undefined data, no clearing pass
// depends on fwm_pkg, fwm_sort_chain, fwm_cell and assert_macros.svh
`include "assert_macros.svh"

module fifo_window_median #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fwm_pkg::S_TDATA_W-1:0]      s_tdata,   // [31:0] value
    input  logic [fwm_pkg::REQ_W-1:0]          s_tuser,   // [1:0] req_type
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [fwm_pkg::M_TDATA_W-1:0]      m_tdata,   // [31:0] median, [40:32] window_count
    output logic [fwm_pkg::STATUS_W-1:0]       m_tuser    // [1:0] status
);
    import fwm_pkg::*;

    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam int AW = $clog2(WINDOW_DEPTH);

    // control state
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [AW-1:0]  oldest_reg, oldest_next;
    logic [AW-1:0]  newest_reg, newest_next;
    logic           m_tvalid_reg, m_tvalid_next;

    // payload
    req_t                       req_reg;
    logic signed [VALUE_W-1:0]  value_reg;
    logic signed [VALUE_W-1:0]  rd_data_reg;
    status_t                    status_reg, status_next;
    logic [M_TDATA_W-1:0]       m_tdata_reg;
    status_t                    m_tuser_reg;

    // arrival order ring
    logic signed [VALUE_W-1:0]  arrival_mem [WINDOW_DEPTH];

    logic                       accept;
    logic                       in_exec;
    logic                       resp_load;
    logic                       do_insert;
    logic                       do_remove;
    logic                       full;
    logic                       empty;
    chain_ctrl_t                chain_ctrl;
    logic signed [VALUE_W-1:0]  chain_key;
    logic signed [VALUE_W-1:0]  median;

    // fsm outputs
    always_comb begin
        s_tready  = 1'b0;
        in_exec   = 1'b0;
        resp_load = 1'b0;
        case (state_reg)
            S_IDLE: s_tready = aresetn;
            S_EXEC: in_exec = 1'b1;
            S_RESP: resp_load = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // fsm next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: state_next = S_RESP;
            S_RESP: begin
                if (resp_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign full  = (count_reg == CW'(WINDOW_DEPTH));
    assign empty = (count_reg == '0);

    // request decode and status
    always_comb begin
        status_next = ST_OK;
        do_insert   = 1'b0;
        do_remove   = 1'b0;
        case (req_reg)
            REQ_INSERT: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    do_insert = in_exec;
                end
            end
            REQ_REMOVE: begin
                if (empty) begin
                    status_next = ST_REMOVE_EMPTY;
                end else begin
                    do_remove = in_exec;
                end
            end
            REQ_QUERY: begin
                if (empty) begin
                    status_next = ST_QUERY_EMPTY;
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    // count and ring pointers, pointers wrap at the window depth
    always_comb begin
        count_next  = count_reg;
        oldest_next = oldest_reg;
        newest_next = newest_reg;
        if (do_insert) begin
            count_next  = count_reg + CW'(1);
            newest_next = (newest_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : newest_reg + AW'(1);
        end else if (do_remove) begin
            count_next  = count_reg - CW'(1);
            oldest_next = (oldest_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : oldest_reg + AW'(1);
        end
    end

    // insert places the new value, remove drops the oldest one read from the ring
    assign chain_ctrl.en = do_insert || do_remove;
    assign chain_ctrl.op = do_remove ? CHAIN_REMOVE : CHAIN_INSERT;
    assign chain_key     = do_remove ? rd_data_reg : value_reg;

    fwm_sort_chain #(
        .DEPTH (WINDOW_DEPTH)
    ) u_chain (
        .aclk   (aclk),
        .ctrl   (chain_ctrl),
        .key    (chain_key),
        .count  (count_reg),
        .median (median)
    );

    // result register, holds until the transfer completes
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (resp_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            oldest_reg   <= '0;
            newest_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            oldest_reg   <= oldest_next;
            newest_reg   <= newest_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg   <= req_t'(s_tuser);
            value_reg <= s_tdata[VALUE_W-1:0];
        end
        if (in_exec) begin
            status_reg <= status_next;
        end
        if (resp_load) begin
            m_tdata_reg <= {(M_TDATA_W - VALUE_W - COUNT_OUT_W)'(0),
                            COUNT_OUT_W'(count_reg), median};
            m_tuser_reg <= status_reg;
        end
    end

    // ring memory, read port follows the oldest pointer every cycle
    always_ff @(posedge aclk) begin
        if (do_insert) begin
            arrival_mem[newest_reg] <= value_reg;
        end
        rd_data_reg <= arrival_mem[oldest_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `FWM_ASSERT(a_count_range, count_reg <= CW'(WINDOW_DEPTH), "window count beyond depth")
    `FWM_ASSERT_NEXT(a_accept_exec, accept, state_reg == S_EXEC, "accepted item not executed")
    `FWM_ASSERT_NEXT(a_ins_grow, do_insert, count_reg == $past(count_reg) + CW'(1), "no growth")
    `FWM_ASSERT_NEXT(a_empty_zero, resp_load && empty, ~|m_tdata[VALUE_W-1:0], "median not zero")

endmodule

/* tb/tb.sv */
// self-checking bench for fifo_window_median: windowed running median over stream transfers
// depends on fwm_pkg for request and status codes; drives the block with random idling
`timescale 1ns / 100ps

module tb;
    import fwm_pkg::*;

    localparam int DEPTH      = 256;   // window size the block is built with
    localparam int N_RANDOM   = 1280;  // random requests after the directed part
    localparam int IDLE_LIMIT = 3000;  // cycles without any transfer before giving up
    localparam int SHOW_MAX   = 10;    // mismatches printed in full

    // one expected result transfer
    typedef struct {
        status_t     status;
        logic [31:0] median;
        logic [8:0]  count;
    } answer_t;

    // running median of the window, kept as an arrival queue and a sorted multiset
    class window_median_tracker;
        logic signed [31:0] arrival_q[$];
        logic signed [31:0] sorted_q[$];
        answer_t            pending_answers[$];
        int                 mismatches;
        int                 checked;
        int                 peak;
        int                 full_rejects;
        int                 empty_rejects;
        int                 dup_inserts;

        function int held();
            return arrival_q.size();
        endfunction

        // work out the result of one accepted request
        function void note_request(req_t req, logic signed [31:0] value);
            answer_t            a;
            int                 pos;
            logic signed [31:0] oldest;
            a.status = ST_OK;
            case (req)
                REQ_INSERT: begin
                    if (arrival_q.size() >= DEPTH) begin
                        a.status = ST_FULL;
                        full_rejects++;
                    end else begin
                        arrival_q.push_back(value);
                        // new value goes after every copy equal to it
                        pos = 0;
                        while (pos < sorted_q.size() && !(value < sorted_q[pos]))
                            pos++;
                        if (pos > 0 && sorted_q[pos-1] == value)
                            dup_inserts++;
                        sorted_q.insert(pos, value);
                    end
                end
                REQ_REMOVE: begin
                    if (arrival_q.size() == 0) begin
                        a.status = ST_REMOVE_EMPTY;
                        empty_rejects++;
                    end else begin
                        oldest = arrival_q.pop_front();
                        pos = 0;
                        while (sorted_q[pos] != oldest)
                            pos++;
                        sorted_q.delete(pos);
                    end
                end
                REQ_QUERY: begin
                    if (arrival_q.size() == 0) begin
                        a.status = ST_QUERY_EMPTY;
                        empty_rejects++;
                    end
                end
                default: ;
            endcase
            a.median = (sorted_q.size() > 0) ? sorted_q[sorted_q.size() / 2] : '0;
            a.count  = 9'(arrival_q.size());
            if (arrival_q.size() > peak)
                peak = arrival_q.size();
            pending_answers.push_back(a);
        endfunction

        // compare one result transfer with the oldest expectation
        function void check_result(status_t status, logic [31:0] median, logic [8:0] count);
            answer_t a;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("unexpected result: status %0d median %0d count %0d",
                             status, $signed(median), count);
                return;
            end
            a = pending_answers.pop_front();
            checked++;
            if (status !== a.status || median !== a.median || count !== a.count) begin
                mismatches++;
                if (mismatches <= SHOW_MAX)
                    $display("result %0d: expected status %0d median %0d count %0d, got %0d %0d %0d",
                             checked, a.status, $signed(a.median), a.count,
                             status, $signed(median), count);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // [31:0] value
    logic [1:0]  s_tuser  = '0;   // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [31:0] median, [40:32] window_count
    logic [1:0]  m_tuser;         // [1:0] status

    window_median_tracker board;

    bit tx_calm;      // sender presents back to back
    bit rx_calm;      // receiver starts no new stalls
    int sent;         // input transfers completed by the driver
    int idle_cycles;  // cycles since the last transfer on either side
    int rx_stall;     // remaining receiver stall cycles

    fifo_window_median #(
        .WINDOW_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 8 ns period
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // insert values: small range for duplicates, the extremes, or anything
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return int'($urandom_range(0, 6)) - 3;
        if (roll < 26) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    // present one request and hold it until the block takes it
    task automatic send_request(req_t req, logic [31:0] value);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sent++;
    endtask

    // hold off the sender until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending_answers.size() != 0)
            @(posedge aclk);
    endtask

    // receiver back-pressure: short stalls mostly, a few long ones
    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (!rx_calm && $urandom_range(0, 99) < 30) begin
            rx_stall = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(9, 39);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // transfer monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_request(req_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready)
                board.check_result(status_t'(m_tuser), m_tdata[31:0], m_tdata[40:32]);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no transfer for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, board.pending_answers.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        bit    filling;
        int    at_edge;
        int    roll;
        int    held;
        req_t  req;

        board = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty window errors, extremes, duplicates, unused code
        send_request(REQ_QUERY,  32'h0000_0000);
        send_request(REQ_REMOVE, 32'hffff_ffff);
        send_request(REQ_NOP,    32'h1234_5678);
        send_request(REQ_INSERT, 32'h7fff_ffff);
        send_request(REQ_INSERT, 32'h8000_0000);
        send_request(REQ_QUERY,  32'haaaa_5555);
        send_request(REQ_INSERT, 32'h0000_0000);
        send_request(REQ_INSERT, 32'hffff_ffff);
        send_request(REQ_INSERT, 32'd5);
        send_request(REQ_INSERT, 32'd5);
        send_request(REQ_INSERT, 32'd5);
        send_request(REQ_QUERY,  32'h5555_aaaa);
        send_request(REQ_NOP,    32'hffff_ffff);
        send_request(REQ_REMOVE, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'h0000_0000);
        send_request(REQ_INSERT, 32'd5);
        send_request(REQ_QUERY,  32'h0000_0000);
        repeat (5) send_request(REQ_REMOVE, 32'h0000_0000);
        send_request(REQ_REMOVE, 32'h0000_0000);
        send_request(REQ_QUERY,  32'h0000_0000);
        wait_drained();

        // random: fill the window to full, drain it to empty, and again;
        // requests against the current trend act as noise
        filling = 1'b1;
        at_edge = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 120 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            held = board.held();
            if ((filling && held >= DEPTH) || (!filling && held == 0))
                at_edge++;
            if (at_edge >= 6) begin
                // turn round once the edge has been pushed on a few times
                filling = !filling;
                at_edge = 0;
                wait_drained();
            end
            roll = $urandom_range(0, 99);
            if (roll < 70)
                req = filling ? REQ_INSERT : REQ_REMOVE;
            else if (roll < 80)
                req = filling ? REQ_REMOVE : REQ_INSERT;
            else if (roll < 95)
                req = REQ_QUERY;
            else
                req = REQ_NOP;
            send_request(req, (req == REQ_INSERT) ? pick_value() : $urandom());
        end

        // end of stimulus: let the last results come back, then a short tail
        wait_drained();
        repeat (12) @(posedge aclk);

        $display("%0d requests sent, %0d results checked, window peak %0d of %0d",
                 sent, board.checked, board.peak, DEPTH);
        $display("%0d inserts when full, %0d empty-window errors, %0d duplicate inserts",
                 board.full_rejects, board.empty_rejects, board.dup_inserts);
        if (board.mismatches == 0 && board.pending_answers.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing",
                     board.mismatches, board.pending_answers.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/fwm_pkg.sv
design/fwm_cell.sv
design/fwm_sort_chain.sv
design/fifo_window_median.sv
tb/tb.sv
